>>> hdl/brf_pkg.sv
// Shared constants for the byte ring FIFO: storage depth, field widths and
// operation codes. No dependencies.
package brf_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = 8;
  localparam int CNT_W  = 9;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  localparam logic [2:0] OP_PUSH        = 3'd0;
  localparam logic [2:0] OP_FORCE       = 3'd1;
  localparam logic [2:0] OP_POP         = 3'd2;
  localparam logic [2:0] OP_PEEK        = 3'd3;
  localparam logic [2:0] OP_DISCARD     = 3'd4;
  localparam logic [2:0] OP_DISCARD_ALL = 3'd5;
  localparam logic [2:0] OP_STATUS      = 3'd6;

endpackage

>>> hdl/byte_ring_fifo_lap_bit.sv
// Byte FIFO over a ring of programmable capacity, with lap bits on both pointers.
// Depends on brf_pkg for depth, widths and operation codes.
//
// Usage:
//   in_*   : one operation per transaction (push, forced push, pop, peek,
//            discard count, discard all, status) with its operands.
//   out_*  : exactly one result transaction per operation: the byte read,
//            ok, and fill level and free space after the operation.
//   cfg_*  : capacity write; also empties the FIFO. Write only while idle.
// The byte store is read, and the pending result registered, at the edge that accepts
// the operation; the output register then loads from that pending stage once it is
// empty or being taken, and presents the result.
// Throughput: one operation per cycle while the output drains; pointers update at
// acceptance and the store has one read and one write port, so a read of a byte written
// by the previous operation sees the new value.
// Reset: capacity 256, head and tail zero, FIFO empty; store contents are
// undefined but never reachable through the operations.
// Stall: while out_ready is low the output register holds; a second result
// waits in the read stage, and in_ready then drops until the output drains.
module byte_ring_fifo_lap_bit
  import brf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_opcode,
  input  logic [7:0]        in_data_in,
  input  logic [7:0]        in_peek_offset,
  input  logic [CNT_W-1:0]  in_discard_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_data_out,
  output logic              out_ok,
  output logic [CNT_W-1:0]  out_fill_level,
  output logic [CNT_W-1:0]  out_free_space,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data
);

  logic [7:0]        mem [DEPTH];

  logic [CNT_W-1:0]  cap_r;
  logic [ADDR_W-1:0] head_idx_r, head_idx_nxt, tail_idx_r, tail_idx_nxt;
  logic              head_lap_r, head_lap_nxt, tail_lap_r, tail_lap_nxt;

  logic              p_valid_r, p_rd_r, p_ok_r;
  logic [CNT_W-1:0]  p_fill_r, p_free_r;
  logic [7:0]        rd_data_r;

  logic              out_valid_r, out_ok_r;
  logic [7:0]        out_data_r;
  logic [CNT_W-1:0]  out_fill_r, out_free_r;

  logic              in_fire, cfg_fire, move;
  logic              wr_en, rd_en, ok_nxt;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  fill, fill_nxt, dcnt, cap_wr;
  logic [ADDR_W:0]   adv_h1, adv_t1, adv_hd, adv_pk;

  function automatic logic [CNT_W-1:0] fill_of(
    input logic [ADDR_W-1:0] hi, input logic hl,
    input logic [ADDR_W-1:0] ti, input logic tl,
    input logic [CNT_W-1:0]  cap
  );
    logic [CNT_W:0] s;
    if (hl == tl) s = {2'b00, ti} - {2'b00, hi};
    else          s = {2'b00, ti} + {1'b0, cap} - {2'b00, hi};
    return s[CNT_W-1:0];
  endfunction

  // Returns {lap flip, new index}.
  function automatic logic [ADDR_W:0] advance(
    input logic [ADDR_W-1:0] idx, input logic [CNT_W-1:0] n,
    input logic [CNT_W-1:0]  cap
  );
    logic [CNT_W:0] s;
    logic           flip;
    s    = {2'b00, idx} + {1'b0, n};
    flip = 1'b0;
    if (s >= {1'b0, cap}) begin
      s    = s - {1'b0, cap};
      flip = 1'b1;
    end
    return {flip, s[ADDR_W-1:0]};
  endfunction

  assign move      = p_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !p_valid_r || move;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = !p_valid_r && !out_valid_r && !in_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign fill   = fill_of(head_idx_r, head_lap_r, tail_idx_r, tail_lap_r, cap_r);
  assign dcnt   = (in_discard_count < fill) ? in_discard_count : fill;
  assign adv_h1 = advance(head_idx_r, CNT_W'(1), cap_r);
  assign adv_t1 = advance(tail_idx_r, CNT_W'(1), cap_r);
  assign adv_hd = advance(head_idx_r, dcnt, cap_r);
  assign adv_pk = advance(head_idx_r, {1'b0, in_peek_offset}, cap_r);

  always_comb begin
    head_idx_nxt = head_idx_r;
    head_lap_nxt = head_lap_r;
    tail_idx_nxt = tail_idx_r;
    tail_lap_nxt = tail_lap_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head_idx_r;
    ok_nxt       = 1'b0;
    unique case (in_opcode)
      OP_PUSH: begin
        if (fill < cap_r) begin
          wr_en        = 1'b1;
          tail_idx_nxt = adv_t1[ADDR_W-1:0];
          tail_lap_nxt = tail_lap_r ^ adv_t1[ADDR_W];
          ok_nxt       = 1'b1;
        end
      end
      OP_FORCE: begin
        if (fill >= cap_r) begin
          head_idx_nxt = adv_h1[ADDR_W-1:0];
          head_lap_nxt = head_lap_r ^ adv_h1[ADDR_W];
        end
        wr_en        = 1'b1;
        tail_idx_nxt = adv_t1[ADDR_W-1:0];
        tail_lap_nxt = tail_lap_r ^ adv_t1[ADDR_W];
        ok_nxt       = 1'b1;
      end
      OP_POP: begin
        if (fill != '0) begin
          rd_en        = 1'b1;
          head_idx_nxt = adv_h1[ADDR_W-1:0];
          head_lap_nxt = head_lap_r ^ adv_h1[ADDR_W];
          ok_nxt       = 1'b1;
        end
      end
      OP_PEEK: begin
        rd_addr = adv_pk[ADDR_W-1:0];
        if ({1'b0, in_peek_offset} < fill) begin
          rd_en  = 1'b1;
          ok_nxt = 1'b1;
        end
      end
      OP_DISCARD: begin
        if (in_discard_count != '0 && fill != '0) begin
          head_idx_nxt = adv_hd[ADDR_W-1:0];
          head_lap_nxt = head_lap_r ^ adv_hd[ADDR_W];
          ok_nxt       = 1'b1;
        end
      end
      OP_DISCARD_ALL: begin
        head_idx_nxt = tail_idx_r;
        head_lap_nxt = tail_lap_r;
        ok_nxt       = (fill != '0);
      end
      OP_STATUS: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  assign fill_nxt = fill_of(head_idx_nxt, head_lap_nxt, tail_idx_nxt, tail_lap_nxt, cap_r);

  always_comb begin
    cap_wr = cfg_data;
    if (cfg_data == '0) cap_wr = CNT_W'(1);
    else if (cfg_data > CNT_W'(DEPTH)) cap_wr = CNT_W'(DEPTH);
  end

  always_ff @(posedge clk) begin
    if (in_fire && wr_en) mem[tail_idx_r] <= in_data_in;
    if (in_fire && rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      head_idx_r <= '0;
      head_lap_r <= 1'b0;
      tail_idx_r <= '0;
      tail_lap_r <= 1'b0;
    end else if (cfg_fire) begin
      cap_r      <= cap_wr;
      head_idx_r <= '0;
      head_lap_r <= 1'b0;
      tail_idx_r <= '0;
      tail_lap_r <= 1'b0;
    end else if (in_fire) begin
      head_idx_r <= head_idx_nxt;
      head_lap_r <= head_lap_nxt;
      tail_idx_r <= tail_idx_nxt;
      tail_lap_r <= tail_lap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)   p_valid_r <= 1'b1;
      else if (move) p_valid_r <= 1'b0;
      if (move)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_rd_r   <= rd_en;
      p_ok_r   <= ok_nxt;
      p_fill_r <= fill_nxt;
      p_free_r <= cap_r - fill_nxt;
    end
    if (move) begin
      out_data_r <= p_rd_r ? rd_data_r : 8'h00;
      out_ok_r   <= p_ok_r;
      out_fill_r <= p_fill_r;
      out_free_r <= p_free_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_ok         = out_ok_r;
  assign out_fill_level = out_fill_r;
  assign out_free_space = out_free_r;

`ifndef ASSERT_OFF
  a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_idx_r} < cap_r && {1'b0, tail_idx_r} < cap_r)
    else $error("pointer beyond capacity");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= cap_r)
    else $error("fill level above capacity");

  a_result_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fill_r + out_free_r == cap_r))
    else $error("fill plus free differs from capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_data_r == 8'h00)
    else $error("failed operation returned data");

  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r && !move |=> p_valid_r && $stable(p_fill_r) &&
    (!p_rd_r || $stable(rd_data_r)))
    else $error("stalled result lost");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for byte_ring_fifo_lap_bit: directed table, then random
// operation sequences over several ring capacities, checked against a local predictor.
// Depends on brf_pkg and the byte_ring_fifo_lap_bit RTL.
module tb
  import brf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 1000;
  localparam int N_PHASES = 9;

  typedef struct {
    logic [2:0]       opcode;
    logic [7:0]       data;
    logic [7:0]       offset;
    logic [CNT_W-1:0] count;
  } op_t;

  typedef struct {
    logic [7:0]       byte_out;
    logic             ok;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] free;
  } res_t;

  typedef struct {
    bit   is_cap;
    op_t  op;
    bit   typed;
    res_t want;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [2:0]       in_opcode = '0;
  logic [7:0]       in_data_in = '0;
  logic [7:0]       in_peek_offset = '0;
  logic [CNT_W-1:0] in_discard_count = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_data_out;
  logic             out_ok;
  logic [CNT_W-1:0] out_fill_level;
  logic [CNT_W-1:0] out_free_space;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  byte_ring_fifo_lap_bit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_data_in       (in_data_in),
    .in_peek_offset   (in_peek_offset),
    .in_discard_count (in_discard_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_out     (out_data_out),
    .out_ok           (out_ok),
    .out_fill_level   (out_fill_level),
    .out_free_space   (out_free_space),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]       ring_mem [DEPTH];
  logic [7:0]       hd_idx = '0;
  logic             hd_lap = 1'b0;
  logic [7:0]       tl_idx = '0;
  logic             tl_lap = 1'b0;
  logic [CNT_W-1:0] ring_cap = CAP_RESET;

  res_t pending_res [$];
  row_t script [$];
  res_t got_res;
  int   idle_mode = 0;
  int   errors = 0;
  int   n_ops = 0;
  int   n_results = 0;
  int   n_caps = 0;
  int   quiet_cycles = 0;

  function automatic logic [CNT_W-1:0] ring_fill();
    int f;
    if (hd_lap == tl_lap) f = int'(tl_idx) - int'(hd_idx);
    else f = int'(tl_idx) + int'(ring_cap) - int'(hd_idx);
    return f[CNT_W-1:0];
  endfunction

  function automatic void ring_advance(inout logic [7:0] idx, inout logic lap, input int n);
    int s;
    s = int'(idx) + n;
    if (s >= int'(ring_cap)) begin
      s -= int'(ring_cap);
      lap = ~lap;
    end
    idx = s[7:0];
  endfunction

  function automatic logic [7:0] ring_at(input logic [7:0] off);
    int p;
    p = int'(hd_idx) + int'(off);
    if (p >= int'(ring_cap)) p -= int'(ring_cap);
    return ring_mem[p[7:0]];
  endfunction

  task automatic fifo_apply(input op_t t, output res_t r);
    logic [CNT_W-1:0] fill;
    int               n;
    fill = ring_fill();
    r = '{byte_out: '0, ok: 1'b0, fill: '0, free: '0};
    case (t.opcode)
      OP_PUSH: begin
        if (fill < ring_cap) begin
          ring_mem[tl_idx] = t.data;
          ring_advance(tl_idx, tl_lap, 1);
          r.ok = 1'b1;
        end
      end
      OP_FORCE: begin
        if (fill >= ring_cap) ring_advance(hd_idx, hd_lap, 1);
        ring_mem[tl_idx] = t.data;
        ring_advance(tl_idx, tl_lap, 1);
        r.ok = 1'b1;
      end
      OP_POP: begin
        if (fill != 0) begin
          r.byte_out = ring_mem[hd_idx];
          ring_advance(hd_idx, hd_lap, 1);
          r.ok = 1'b1;
        end
      end
      OP_PEEK: begin
        if (CNT_W'(t.offset) < fill) begin
          r.byte_out = ring_at(t.offset);
          r.ok = 1'b1;
        end
      end
      OP_DISCARD: begin
        if (t.count != 0 && fill != 0) begin
          n = (t.count < fill) ? int'(t.count) : int'(fill);
          ring_advance(hd_idx, hd_lap, n);
          r.ok = 1'b1;
        end
      end
      OP_DISCARD_ALL: begin
        r.ok = (fill != 0);
        hd_idx = tl_idx;
        hd_lap = tl_lap;
      end
      OP_STATUS: r.ok = 1'b1;
      default: ;
    endcase
    fill = ring_fill();
    r.fill = fill;
    r.free = ring_cap - fill;
  endtask

  function automatic bit sender_gap();
    if (idle_mode == 1) return $urandom_range(99) < 63;
    if (idle_mode == 3) return $urandom_range(99) < 9;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if ((idle_mode == 2 && $urandom_range(99) < 63) || (idle_mode == 3 && $urandom_range(99) < 9))
      out_ready <= 1'b0;
    else
      out_ready <= 1'b1;
  end

  task automatic send_op(input op_t t, input bit typed, input res_t want);
    res_t r;
    while (sender_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= t.opcode;
    in_data_in       <= t.data;
    in_peek_offset   <= t.offset;
    in_discard_count <= t.count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fifo_apply(t, r);
    pending_res.push_back(typed ? want : r);
    n_ops++;
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (v == 0) ring_cap = CNT_W'(1);
    else if (v > DEPTH) ring_cap = CNT_W'(DEPTH);
    else ring_cap = v;
    hd_idx = '0;
    hd_lap = 1'b0;
    tl_idx = '0;
    tl_lap = 1'b0;
    n_caps++;
  endtask

  function automatic row_t op_row(logic [2:0] opc, logic [7:0] d, logic [7:0] o,
                                  logic [CNT_W-1:0] c);
    row_t w;
    w.is_cap = 1'b0;
    w.op     = '{opcode: opc, data: d, offset: o, count: c};
    w.typed  = 1'b0;
    w.want   = '{byte_out: '0, ok: 1'b0, fill: '0, free: '0};
    return w;
  endfunction

  function automatic row_t op_chk(logic [2:0] opc, logic [7:0] d, logic [7:0] o,
                                  logic [CNT_W-1:0] c, logic [7:0] dout, logic ok,
                                  logic [CNT_W-1:0] fl, logic [CNT_W-1:0] fr);
    row_t w;
    w       = op_row(opc, d, o, c);
    w.typed = 1'b1;
    w.want  = '{byte_out: dout, ok: ok, fill: fl, free: fr};
    return w;
  endfunction

  function automatic row_t cap_row(logic [CNT_W-1:0] v);
    row_t w;
    w        = op_row(OP_STATUS, 8'h00, 8'h00, v);
    w.is_cap = 1'b1;
    return w;
  endfunction

  function automatic op_t random_op(int push_pct);
    op_t              t;
    logic [CNT_W-1:0] fill;
    int               r;
    fill = ring_fill();
    t.data   = 8'($urandom_range(255));
    t.offset = 8'($urandom_range(255));
    t.count  = CNT_W'($urandom_range(DEPTH));
    if ($urandom_range(99) < push_pct) begin
      t.opcode = ($urandom_range(3) == 0) ? OP_FORCE : OP_PUSH;
    end else begin
      r = $urandom_range(99);
      if (r < 35) t.opcode = OP_POP;
      else if (r < 60) t.opcode = OP_PEEK;
      else if (r < 72) t.opcode = OP_DISCARD;
      else if (r < 77) t.opcode = OP_DISCARD_ALL;
      else if (r < 94) t.opcode = OP_STATUS;
      else t.opcode = OP_UNUSED;
    end
    if (fill != 0 && $urandom_range(3) != 0) t.offset = 8'($urandom_range(int'(fill) - 1));
    if ($urandom_range(1) == 1) t.count = CNT_W'($urandom_range(int'(fill)));
    return t;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none, actual data %0d ok %0d fill %0d",
                 $time, out_data_out, out_ok, out_fill_level);
      end else begin
        got_res = pending_res.pop_front();
        check_field("data_out", got_res.byte_out, out_data_out);
        check_field("ok", got_res.ok, out_ok);
        check_field("fill_level", got_res.fill, out_fill_level);
        check_field("free_space", got_res.free, out_free_space);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  int ph_cap   [N_PHASES] = '{1, 2, 0, 3, 16, 255, 256, 511, 100};
  int ph_items [N_PHASES] = '{50, 50, 40, 50, 70, 60, 300, 45, 60};
  int ph_push  [N_PHASES] = '{60, 60, 60, 60, 70, 55, 97, 50, 80};

  initial begin
    res_t none;
    bit   reached_full;
    none = '{byte_out: '0, ok: 1'b0, fill: '0, free: '0};

    script.push_back(op_chk(OP_STATUS,      8'h00, 8'h00, 9'd0,   8'h00, 1'b1, 9'd0, 9'd256));
    script.push_back(op_chk(OP_POP,         8'h00, 8'h00, 9'd0,   8'h00, 1'b0, 9'd0, 9'd256));
    script.push_back(op_chk(OP_PEEK,        8'h00, 8'h00, 9'd0,   8'h00, 1'b0, 9'd0, 9'd256));
    script.push_back(op_chk(OP_DISCARD,     8'h00, 8'h00, 9'd5,   8'h00, 1'b0, 9'd0, 9'd256));
    script.push_back(op_chk(OP_DISCARD_ALL, 8'h00, 8'h00, 9'd0,   8'h00, 1'b0, 9'd0, 9'd256));
    script.push_back(op_chk(OP_UNUSED,      8'hFF, 8'hFF, 9'd256, 8'h00, 1'b0, 9'd0, 9'd256));
    script.push_back(op_chk(OP_PUSH,        8'hFF, 8'h00, 9'd0,   8'h00, 1'b1, 9'd1, 9'd255));
    script.push_back(op_chk(OP_PUSH,        8'h00, 8'h00, 9'd0,   8'h00, 1'b1, 9'd2, 9'd254));
    script.push_back(op_chk(OP_FORCE,       8'hA5, 8'h00, 9'd0,   8'h00, 1'b1, 9'd3, 9'd253));
    script.push_back(op_chk(OP_PEEK,        8'h00, 8'h00, 9'd0,   8'hFF, 1'b1, 9'd3, 9'd253));
    script.push_back(op_chk(OP_PEEK,        8'h00, 8'h02, 9'd0,   8'hA5, 1'b1, 9'd3, 9'd253));
    script.push_back(op_chk(OP_PEEK,        8'h00, 8'hFF, 9'd0,   8'h00, 1'b0, 9'd3, 9'd253));
    script.push_back(op_chk(OP_POP,         8'h00, 8'h00, 9'd0,   8'hFF, 1'b1, 9'd2, 9'd254));
    script.push_back(op_chk(OP_DISCARD,     8'h00, 8'h00, 9'd0,   8'h00, 1'b0, 9'd2, 9'd254));
    script.push_back(op_chk(OP_DISCARD,     8'h00, 8'h00, 9'd256, 8'h00, 1'b1, 9'd0, 9'd256));
    script.push_back(op_row(OP_PUSH,        8'h5A, 8'h00, 9'd0));
    script.push_back(op_row(OP_PUSH,        8'h3C, 8'h00, 9'd0));
    script.push_back(op_row(OP_DISCARD,     8'h00, 8'h00, 9'd1));
    script.push_back(op_row(OP_POP,         8'h00, 8'h00, 9'd0));
    script.push_back(cap_row(9'd0));
    script.push_back(op_chk(OP_PUSH,        8'h11, 8'h00, 9'd0,   8'h00, 1'b1, 9'd1, 9'd0));
    script.push_back(op_chk(OP_PUSH,        8'h22, 8'h00, 9'd0,   8'h00, 1'b0, 9'd1, 9'd0));
    script.push_back(op_chk(OP_FORCE,       8'h33, 8'h00, 9'd0,   8'h00, 1'b1, 9'd1, 9'd0));
    script.push_back(op_chk(OP_POP,         8'h00, 8'h00, 9'd0,   8'h33, 1'b1, 9'd0, 9'd1));
    script.push_back(op_chk(OP_FORCE,       8'h44, 8'h00, 9'd0,   8'h00, 1'b1, 9'd1, 9'd0));
    script.push_back(op_chk(OP_DISCARD_ALL, 8'h00, 8'h00, 9'd0,   8'h00, 1'b1, 9'd0, 9'd1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cap) write_capacity(script[i].op.count);
      else send_op(script[i].op, script[i].typed, script[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(CNT_W'(ph_cap[p]));
      idle_mode    = p % 4;
      reached_full = 1'b0;
      for (int k = 0; k < ph_items[p]; k++) begin
        if (ring_fill() == ring_cap) reached_full = 1'b1;
        send_op(random_op(reached_full ? 50 : ph_push[p]), 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d operations across %0d capacity writes with four idling patterns;",
             n_ops, n_caps);
    $display("checked %0d results, %0d mismatches.", n_results, errors);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> byte_ring_fifo_lap_bit.f
hdl/brf_pkg.sv
hdl/byte_ring_fifo_lap_bit.sv
tb/tb.sv
